>>> rtl/core/odq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// odq_pkg
// Shared types and constants of the offset-indexed deque: request and
// response payloads, command and status codes, cell control.
// ----------------------------------------------------------------------------
package odq_pkg;

  localparam int DATA_W       = 32;
  localparam int IDX_W        = 16;
  localparam int CMD_W        = 3;
  localparam int FILL_W       = 7;
  localparam int STATUS_W     = 2;
  localparam int OCC_W        = 7;
  localparam int CAPACITY_DEF = 64;
  localparam int GROUP        = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_READ       = 3'd4,
    CMD_WRITE      = 3'd5,
    CMD_FILL       = 3'd6
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN,
    CELL_WRITE,
    CELL_FILL
  } cell_op_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_GROUP,
    FSM_MERGE
  } fsm_e;

  typedef struct packed {
    cell_op_e op;
    logic     tap;
  } cell_ctrl_t;

  typedef struct packed {
    logic        [CMD_W-1:0]  command;
    logic signed [DATA_W-1:0] value;
    logic signed [IDX_W-1:0]  index;
    logic        [FILL_W-1:0] fill_count;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]   data;
    logic        [STATUS_W-1:0] status;
    logic        [OCC_W-1:0]    occupancy;
  } rsp_t;

endpackage
`default_nettype wire

>>> rtl/core/odq_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// odq_req_if
// Request channel of the deque: valid/ready handshake with command payload.
// ----------------------------------------------------------------------------
interface odq_req_if;
  import odq_pkg::*;

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface
`default_nettype wire

>>> rtl/core/odq_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// odq_rsp_if
// Response channel of the deque: valid/ready handshake with result payload.
// ----------------------------------------------------------------------------
interface odq_rsp_if;
  import odq_pkg::*;

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface
`default_nettype wire

>>> rtl/core/odq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// odq_cell
// One element slot of the deque chain. Holds the word at logical position
// POS, shifts toward either neighbor, takes writes and fills, and drives a
// registered tap when it is the read target.
// ----------------------------------------------------------------------------
module odq_cell #(
  parameter int CW  = 7,
  parameter int POS = 0
) (
  input  wire                             clk_i,
  input  wire odq_pkg::cell_ctrl_t        ctrl_i,
  input  wire  [CW-1:0]                   target_i,
  input  wire  [odq_pkg::DATA_W-1:0]      value_i,
  input  wire  [odq_pkg::DATA_W-1:0]      lower_i,
  input  wire  [odq_pkg::DATA_W-1:0]      upper_i,
  output logic [odq_pkg::DATA_W-1:0]      data_o,
  output logic [odq_pkg::DATA_W-1:0]      tap_o
);
  import odq_pkg::*;

  localparam logic [CW-1:0] POS_C = CW'(POS);

  logic [DATA_W-1:0] data_d, data_q;
  logic [DATA_W-1:0] tap_d, tap_q;
  logic              hit;

  assign hit = (target_i == POS_C);

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_SHIFT_UP:   data_d = lower_i;
      CELL_SHIFT_DOWN: data_d = upper_i;
      CELL_WRITE: begin
        if (hit) data_d = value_i;
      end
      CELL_FILL: begin
        if (POS_C < target_i) data_d = value_i;
      end
      default: data_d = data_q;
    endcase
  end

  assign tap_d = (ctrl_i.tap && hit) ? data_q : '0;

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    tap_q  <= tap_d;
  end

  assign data_o = data_q;
  assign tap_o  = tap_q;

endmodule
`default_nettype wire

>>> rtl/core/odq_gather.sv
`default_nettype none
// ----------------------------------------------------------------------------
// odq_gather
// Two-stage registered OR tree that collects the one active cell tap into
// the response data register.
// ----------------------------------------------------------------------------
module odq_gather #(
  parameter int N = 64
) (
  input  wire                                   clk_i,
  input  wire  [N-1:0][odq_pkg::DATA_W-1:0]     taps_i,
  input  wire                                   load_i,
  output logic [odq_pkg::DATA_W-1:0]            data_o
);
  import odq_pkg::*;

  localparam int NG = (N + GROUP - 1) / GROUP;

  logic [NG-1:0][DATA_W-1:0] grp_d, grp_q;
  logic [DATA_W-1:0]         merge_d, data_q;

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        if (g * GROUP + j < N) grp_d[g] = grp_d[g] | taps_i[g * GROUP + j];
      end
    end
  end

  always_comb begin
    merge_d = '0;
    for (int g = 0; g < NG; g++) merge_d = merge_d | grp_q[g];
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    if (load_i) data_q <= merge_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

>>> rtl/core/offset_indexed_deque.sv
`default_nettype none
// ----------------------------------------------------------------------------
// offset_indexed_deque
// Bounded double-ended queue of signed 32-bit words held in a chain of
// cells in logical order, addressed by index relative to low_bound.
// ----------------------------------------------------------------------------
// Every accepted request passes through the GROUP and MERGE states before
// its response is raised. A new request is taken once the block is idle
// and the previous response has left or leaves in the same cycle, so no
// request is taken before the last one is through. These states are set by
// the read path: the addressed cell registers its word, and a two-stage
// registered OR tree over the cell row brings it to the response register.
// Element k from the front always sits in cell k; pushes and pops at the
// front shift the whole row by one cell, and fill rewrites the first
// fill_count cells. Failed commands report their status with data zero
// and leave the contents alone.
module offset_indexed_deque #(
  parameter int CAPACITY = odq_pkg::CAPACITY_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [odq_pkg::IDX_W-1:0]    cfg_wdata_i,
  odq_req_if.sink                      req,
  odq_rsp_if.source                    rsp
);
  import odq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  fsm_e                      state_d, state_q;
  logic [CW-1:0]             count_d, count_q;
  logic [IDX_W-1:0]          low_q;
  status_e                   status_d, status_q;
  logic [OCC_W-1:0]          occ_q;
  logic                      out_valid_d, out_valid_q;
  logic                      accept;
  logic                      in_ready;
  cmd_e                      cmd;
  logic signed [IDX_W:0]     offset;
  logic                      in_range;
  logic                      full, empty, fill_ok;
  cell_ctrl_t                ctrl;
  logic [CW-1:0]             target;
  logic [CAPACITY-1:0][DATA_W-1:0] cell_data;
  logic [CAPACITY-1:0][DATA_W-1:0] cell_tap;
  logic [DATA_W-1:0]         gather_data;

  assign accept   = req.valid && in_ready;
  assign cmd      = cmd_e'(req.payload.command);
  assign offset   = {req.payload.index[IDX_W-1], req.payload.index}
                  - {low_q[IDX_W-1], low_q};
  assign in_range = !offset[IDX_W] && (32'(offset[IDX_W-1:0]) < 32'(count_q));
  assign full     = (count_q == CW'(CAPACITY));
  assign empty    = (count_q == '0);
  assign fill_ok  = (32'(req.payload.fill_count) <= CAPACITY);

  always_comb begin
    ctrl     = '{op: CELL_HOLD, tap: 1'b0};
    target   = '0;
    count_d  = count_q;
    status_d = STAT_OK;
    if (accept) begin
      case (cmd)
        CMD_PUSH_BACK: begin
          if (full) status_d = STAT_FULL;
          else begin
            ctrl.op = CELL_WRITE;
            target  = count_q;
            count_d = count_q + 1'b1;
          end
        end
        CMD_PUSH_FRONT: begin
          if (full) status_d = STAT_FULL;
          else begin
            ctrl.op = CELL_SHIFT_UP;
            count_d = count_q + 1'b1;
          end
        end
        CMD_POP_BACK: begin
          if (empty) status_d = STAT_EMPTY;
          else begin
            ctrl.tap = 1'b1;
            target   = count_q - 1'b1;
            count_d  = count_q - 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (empty) status_d = STAT_EMPTY;
          else begin
            ctrl.op  = CELL_SHIFT_DOWN;
            ctrl.tap = 1'b1;
            count_d  = count_q - 1'b1;
          end
        end
        CMD_READ: begin
          if (!in_range) status_d = STAT_RANGE;
          else begin
            ctrl.tap = 1'b1;
            target   = CW'(offset[IDX_W-1:0]);
          end
        end
        CMD_WRITE: begin
          if (!in_range) status_d = STAT_RANGE;
          else begin
            ctrl.op = CELL_WRITE;
            target  = CW'(offset[IDX_W-1:0]);
          end
        end
        CMD_FILL: begin
          if (!fill_ok) status_d = STAT_FULL;
          else begin
            ctrl.op = CELL_FILL;
            target  = CW'(req.payload.fill_count);
            count_d = CW'(req.payload.fill_count);
          end
        end
        default: status_d = STAT_OK;
      endcase
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_W-1:0] lower, upper;
    if (k == 0) begin : g_head
      assign lower = req.payload.value;
    end else begin : g_body
      assign lower = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_tail
      assign upper = cell_data[k];
    end else begin : g_mid
      assign upper = cell_data[k+1];
    end
    odq_cell #(
      .CW  (CW),
      .POS (k)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .target_i (target),
      .value_i  (req.payload.value),
      .lower_i  (lower),
      .upper_i  (upper),
      .data_o   (cell_data[k]),
      .tap_o    (cell_tap[k])
    );
  end

  odq_gather #(
    .N (CAPACITY)
  ) u_gather (
    .clk_i  (clk_i),
    .taps_i (cell_tap),
    .load_i (state_q == FSM_MERGE),
    .data_o (gather_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE:  if (accept) state_d = FSM_GROUP;
      FSM_GROUP: state_d = FSM_MERGE;
      FSM_MERGE: state_d = FSM_IDLE;
      default:   state_d = FSM_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    out_valid_d = out_valid_q && !rsp.ready;
    case (state_q)
      FSM_IDLE:  in_ready    = !out_valid_q || rsp.ready;
      FSM_MERGE: out_valid_d = 1'b1;
      default:   in_ready    = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      low_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) low_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      occ_q    <= OCC_W'(count_d);
    end
  end

  assign req.ready             = in_ready;
  assign rsp.valid             = out_valid_q;
  assign rsp.payload.data      = gather_data;
  assign rsp.payload.status    = status_q;
  assign rsp.payload.occupancy = occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= CAPACITY)
    else $error("element count above capacity");

  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == FSM_GROUP)
    else $error("accepted request did not enter the gather sequence");

  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == FSM_MERGE))
    else $error("response raised outside the merge step");

  a_fail_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && status_d != STAT_OK |=> $stable(count_q))
    else $error("failed request changed the element count");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != STAT_OK |-> gather_data == '0)
    else $error("failed request returned nonzero data");

endmodule
`default_nettype wire
